>>> rtl/core/assert_macros.svh
// Concurrent assertion helpers; the synthesis build sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// ante true -> cons true in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// ante true -> cons true in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> rtl/core/prmom_pkg.sv
package prmom_pkg;

  // Q2.22 atmospheres
  localparam int unsigned PRES_W  = 24;
  localparam int unsigned SPM_DEF = 10;
  localparam int unsigned MK_DEF  = 10;

  localparam logic [PRES_W-1:0] ONE_ATM = {2'b01, {(PRES_W-2){1'b0}}};

  // controller -> datapath commands
  typedef struct packed {
    logic wr_sample;        // write request sample into sample ring
    logic ref_from_sample;  // reference follows the sample
    logic srt_clr;          // flush the sorter
    logic rd_en;            // read ring entry at rd_idx
    logic med_sel;          // 0: sample ring, 1: median ring
    logic wr_median;        // push sorter median into median ring
    logic ref_from_median;  // reference takes the sorter median
    logic load_out;         // load result register
    logic taken;            // window median taken for this request
    logic settled;          // median ring full
  } prmom_cmd_t;

endpackage

>>> rtl/core/prmom_if.sv
interface prmom_in_if import prmom_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRES_W-1:0] pressure_sample;

  modport source (output valid, output pressure_sample, input ready);
  modport sink   (input valid, input pressure_sample, output ready);
endinterface

interface prmom_out_if import prmom_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRES_W-1:0] pressure_reference;
  logic              median_taken;
  logic              reference_settled;

  modport source (output valid, output pressure_reference, output median_taken,
                  output reference_settled, input ready);
  modport sink   (input valid, input pressure_reference, input median_taken,
                  input reference_settled, output ready);
endinterface

>>> rtl/core/prmom_sorter.sv
// Insertion sorter: one value per cycle, each cell compares against the
// incoming value in parallel. Flushed to all ones so unused tail cells sit
// at or above any real value.
module prmom_sorter import prmom_pkg::*; #(
  parameter int unsigned N_A = SPM_DEF,
  parameter int unsigned N_B = MK_DEF
) (
  input  logic              clk,
  input  logic              clr,
  input  logic              ins,
  input  logic [PRES_W-1:0] ins_val,
  input  logic              sel_b,
  output logic [PRES_W-1:0] median
);

  localparam int unsigned DEPTH = (N_A > N_B) ? N_A : N_B;
  localparam int unsigned LO_A  = (N_A - 1) / 2;
  localparam int unsigned HI_A  = N_A / 2;
  localparam int unsigned LO_B  = (N_B - 1) / 2;
  localparam int unsigned HI_B  = N_B / 2;

  logic [PRES_W-1:0] srt_r   [DEPTH];
  logic [PRES_W-1:0] srt_nxt [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic              keep;
    logic              lower_ok;
    logic [PRES_W-1:0] prev;

    assign keep = srt_r[g] <= ins_val;
    if (g == 0) begin : g_first
      assign lower_ok = 1'b1;
      assign prev     = ins_val;
    end else begin : g_rest
      assign lower_ok = srt_r[g-1] <= ins_val;
      assign prev     = srt_r[g-1];
    end

    always_comb begin
      if (clr) begin
        srt_nxt[g] = '1;
      end else if (keep) begin
        srt_nxt[g] = srt_r[g];
      end else begin
        srt_nxt[g] = lower_ok ? ins_val : prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr || ins) begin
      srt_r <= srt_nxt;
    end
  end

  // odd count: lo == hi, so the mean is the middle entry itself
  logic [PRES_W-1:0] lo_val;
  logic [PRES_W-1:0] hi_val;
  logic [PRES_W:0]   mid_sum;

  assign lo_val  = sel_b ? srt_r[LO_B] : srt_r[LO_A];
  assign hi_val  = sel_b ? srt_r[HI_B] : srt_r[HI_A];
  assign mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
  assign median  = mid_sum[PRES_W:1];

endmodule

>>> rtl/core/prmom_ctrl.sv
module prmom_ctrl import prmom_pkg::*; #(
  parameter int unsigned SPM = SPM_DEF,
  parameter int unsigned MK  = MK_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  output prmom_cmd_t                  cmd,
  output logic [$clog2(SPM)-1:0]      smp_slot,
  output logic [$clog2(MK)-1:0]       med_slot,
  output logic [$clog2(((SPM > MK) ? SPM : MK) + 1)-1:0] rd_idx
);

  localparam int unsigned SIW  = $clog2(SPM);
  localparam int unsigned MIW  = $clog2(MK);
  localparam int unsigned HW   = $clog2(MK + 1);
  localparam int unsigned NMAX = (SPM > MK) ? SPM : MK;
  localparam int unsigned IW   = $clog2(NMAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SORT = 4'b0010,
    ST_MED  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t           state_r,    state_nxt;
  logic [SIW-1:0]   smp_slot_r, smp_slot_nxt;
  logic [SIW-1:0]   since_r,    since_nxt;
  logic [MIW-1:0]   med_slot_r, med_slot_nxt;
  logic [HW-1:0]    held_r,     held_nxt;
  logic [IW-1:0]    idx_r,      idx_nxt;
  logic             phase_r,    phase_nxt;
  logic             taken_r,    taken_nxt;
  logic             out_vld_r,  out_vld_nxt;
  logic [IW-1:0]    sort_len;

  assign sort_len = phase_r ? IW'(MK) : IW'(SPM);

  always_comb begin
    state_nxt    = state_r;
    smp_slot_nxt = smp_slot_r;
    since_nxt    = since_r;
    med_slot_nxt = med_slot_r;
    held_nxt     = held_r;
    idx_nxt      = idx_r;
    phase_nxt    = phase_r;
    taken_nxt    = taken_r;
    cmd          = '0;
    cmd.med_sel  = phase_r;
    cmd.taken    = taken_r;
    cmd.settled  = held_r == HW'(MK);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.wr_sample       = 1'b1;
          cmd.ref_from_sample = held_r == '0;
          smp_slot_nxt = (smp_slot_r == SIW'(SPM - 1)) ? '0 : smp_slot_r + 1'b1;
          if (since_r == SIW'(SPM - 1)) begin
            since_nxt   = '0;
            taken_nxt   = 1'b1;
            if (held_r != HW'(MK)) begin
              held_nxt = held_r + 1'b1;
            end
            phase_nxt   = 1'b0;
            idx_nxt     = '0;
            cmd.srt_clr = 1'b1;
            state_nxt   = ST_SORT;
          end else begin
            since_nxt = since_r + 1'b1;
            taken_nxt = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SORT: begin
        // last read lands in the sorter on the edge into ST_MED
        if (idx_r == sort_len) begin
          state_nxt = ST_MED;
        end else begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_MED: begin
        if (!phase_r) begin
          cmd.wr_median = 1'b1;
          med_slot_nxt  = (med_slot_r == MIW'(MK - 1)) ? '0 : med_slot_r + 1'b1;
          if (held_r == HW'(MK)) begin
            phase_nxt   = 1'b1;
            idx_nxt     = '0;
            cmd.srt_clr = 1'b1;
            state_nxt   = ST_SORT;
          end else begin
            cmd.ref_from_median = 1'b1;
            state_nxt           = ST_DONE;
          end
        end else begin
          cmd.ref_from_median = 1'b1;
          state_nxt           = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      smp_slot_r <= '0;
      since_r    <= '0;
      med_slot_r <= '0;
      held_r     <= '0;
      idx_r      <= '0;
      phase_r    <= 1'b0;
      taken_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      smp_slot_r <= smp_slot_nxt;
      since_r    <= since_nxt;
      med_slot_r <= med_slot_nxt;
      held_r     <= held_nxt;
      idx_r      <= idx_nxt;
      phase_r    <= phase_nxt;
      taken_r    <= taken_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_vld_r;
  assign smp_slot  = smp_slot_r;
  assign med_slot  = med_slot_r;
  assign rd_idx    = idx_r;

endmodule

>>> rtl/core/prmom_dpath.sv
module prmom_dpath import prmom_pkg::*; #(
  parameter int unsigned SPM = SPM_DEF,
  parameter int unsigned MK  = MK_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prmom_cmd_t                  cmd,
  input  logic [$clog2(SPM)-1:0]      smp_slot,
  input  logic [$clog2(MK)-1:0]       med_slot,
  input  logic [$clog2(((SPM > MK) ? SPM : MK) + 1)-1:0] rd_idx,
  input  logic [PRES_W-1:0]           in_sample,
  output logic [PRES_W-1:0]           out_ref,
  output logic                        out_taken,
  output logic                        out_settled
);

  localparam int unsigned SIW = $clog2(SPM);
  localparam int unsigned MIW = $clog2(MK);

  logic [PRES_W-1:0] smp_mem [SPM];
  logic [PRES_W-1:0] med_mem [MK];
  logic [PRES_W-1:0] smp_rd_r;
  logic [PRES_W-1:0] med_rd_r;
  logic              rd_vld_r;
  logic [PRES_W-1:0] ref_r;
  logic [PRES_W-1:0] out_ref_r;
  logic              out_taken_r;
  logic              out_settled_r;
  logic [PRES_W-1:0] median;
  logic [PRES_W-1:0] ins_val;

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      smp_mem[smp_slot] <= in_sample;
    end
    if (cmd.rd_en && !cmd.med_sel) begin
      smp_rd_r <= smp_mem[rd_idx[SIW-1:0]];
    end
  end

  // median ring
  always_ff @(posedge clk) begin
    if (cmd.wr_median) begin
      med_mem[med_slot] <= median;
    end
    if (cmd.rd_en && cmd.med_sel) begin
      med_rd_r <= med_mem[rd_idx[MIW-1:0]];
    end
  end

  assign ins_val = cmd.med_sel ? med_rd_r : smp_rd_r;

  prmom_sorter #(
    .N_A (SPM),
    .N_B (MK)
  ) u_sorter (
    .clk     (clk),
    .clr     (cmd.srt_clr),
    .ins     (rd_vld_r),
    .ins_val (ins_val),
    .sel_b   (cmd.med_sel),
    .median  (median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      ref_r    <= ONE_ATM;
    end else begin
      rd_vld_r <= cmd.rd_en;
      priority if (cmd.ref_from_sample) begin
        ref_r <= in_sample;
      end else if (cmd.ref_from_median) begin
        ref_r <= median;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ref_r     <= ref_r;
      out_taken_r   <= cmd.taken;
      out_settled_r <= cmd.settled;
    end
  end

  assign out_ref     = out_ref_r;
  assign out_taken   = out_taken_r;
  assign out_settled = out_settled_r;

endmodule

>>> rtl/core/pressure_reference_median_of_medians.sv
// Ground pressure reference by running median of medians. Each request is one
// unsigned Q2.22 atm pressure sample; each one yields exactly one result. The
// last SAMPLES_PER_MEDIAN samples sit in a ring; every SAMPLES_PER_MEDIAN-th
// sample closes a window whose median (mean of the middle two for an even
// count, truncated) is pushed into a ring of the last MEDIANS_KEPT medians.
// The reference tracks the raw sample until the first median exists, then the
// newest median, and once MEDIANS_KEPT medians are held the median of that
// ring (reference_settled goes high). Reset reference is 1.0 atm. One request
// is in work at a time: a sample that closes no window goes straight to the
// result stage, one that closes a window first sorts the sample ring and pushes
// the window median, and one that also re-sorts the full median ring runs a
// second sort pass over it. Both passes share the single insertion sorter, fed
// one ring entry per cycle through each ring memory's registered read port. A
// held result register lets the next request in while a result waits; a
// request finishing while the previous result is still unread waits for it.
`include "assert_macros.svh"

module pressure_reference_median_of_medians import prmom_pkg::*; #(
  parameter int unsigned SAMPLES_PER_MEDIAN = SPM_DEF,
  parameter int unsigned MEDIANS_KEPT       = MK_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  prmom_in_if.sink     in_chan,
  prmom_out_if.source  out_chan
);

  localparam int unsigned SIW  = $clog2(SAMPLES_PER_MEDIAN);
  localparam int unsigned MIW  = $clog2(MEDIANS_KEPT);
  localparam int unsigned NMAX = (SAMPLES_PER_MEDIAN > MEDIANS_KEPT) ?
                                 SAMPLES_PER_MEDIAN : MEDIANS_KEPT;
  localparam int unsigned IW   = $clog2(NMAX + 1);

  prmom_cmd_t     cmd;
  logic [SIW-1:0] smp_slot;
  logic [MIW-1:0] med_slot;
  logic [IW-1:0]  rd_idx;

  // sequencing: counters, ring slots, sort passes, result handshake
  prmom_ctrl #(
    .SPM (SAMPLES_PER_MEDIAN),
    .MK  (MEDIANS_KEPT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd),
    .smp_slot  (smp_slot),
    .med_slot  (med_slot),
    .rd_idx    (rd_idx)
  );

  // rings, sorter, reference and result payload
  prmom_dpath #(
    .SPM (SAMPLES_PER_MEDIAN),
    .MK  (MEDIANS_KEPT)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .smp_slot    (smp_slot),
    .med_slot    (med_slot),
    .rd_idx      (rd_idx),
    .in_sample   (in_chan.pressure_sample),
    .out_ref     (out_chan.pressure_reference),
    .out_taken   (out_chan.median_taken),
    .out_settled (out_chan.reference_settled)
  );

  // a loaded result is presented the next cycle
  `ASSERT_NEXT(a_load_presents, clk, rst_n, cmd.load_out, out_chan.valid)
  // one request in work: no new request right after one is taken
  `ASSERT_NEXT(a_one_in_work, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)
  // sorter feed only while the input side is closed
  `ASSERT_IMPLIES(a_sort_closed, clk, rst_n, cmd.rd_en, !in_chan.ready)
  // reference has a single source per cycle
  `ASSERT_NEVER(a_ref_one_src, clk, rst_n, cmd.ref_from_sample && cmd.ref_from_median)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the ground pressure reference filter (running median of medians).
// Every request carries one pressure sample and produces exactly one result.
// The expected result is computed when the request is accepted, queued, and
// compared field by field with each result as it comes out.
module tb;
  import prmom_pkg::*;

  localparam int unsigned SPM = SPM_DEF;
  localparam int unsigned MK  = MK_DEF;

  // Leave generous margin over the longest request, one that re-sorts both rings.
  localparam int DRAIN_CYCLES   = 4 * (SPM + MK + 6);
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_GAP        = 17;

  typedef struct packed {
    logic [PRES_W-1:0] reference;
    logic              taken;
    logic              settled;
  } pres_result_t;

  logic clk;
  logic rst_n;

  prmom_in_if  in_chan ();
  prmom_out_if out_chan ();

  pressure_reference_median_of_medians #(
    .SAMPLES_PER_MEDIAN (SPM),
    .MEDIANS_KEPT       (MK)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of both rings, their write slots and counters.
  // ---------------------------------------------------------------------------
  logic [PRES_W-1:0] window_ring [SPM];
  logic [PRES_W-1:0] median_ring [MK];
  logic [PRES_W-1:0] sort_buf [32];
  int unsigned       window_slot;
  int unsigned       window_fill;     // samples since the last window median
  int unsigned       median_slot;
  int unsigned       medians_held;    // saturates at MK
  logic [PRES_W-1:0] ref_level;

  pres_result_t pending_refs [$];     // expected results, oldest first
  pres_result_t expected_ref;
  int           mismatch_count;
  int           stall_cycles;

  // Idling controls shared by the test tasks, the sender task and the receiver process.
  bit src_idle_on;
  bit sink_idle_on;
  int sink_hold_cycles;
  int drift_level;

  // Insertion sort over sort_buf[0:n-1]; even n averages the two middle
  // entries with one extra bit so that two near-full values do not wrap.
  function automatic logic [PRES_W-1:0] middle_of_scratch(input int n);
    int                i;
    int                j;
    logic [PRES_W-1:0] v;
    logic [PRES_W:0]   sum;
    for (i = 1; i < n; i++) begin
      v = sort_buf[i];
      j = i;
      while (j > 0 && v < sort_buf[j-1]) begin
        sort_buf[j] = sort_buf[j-1];
        j--;
      end
      sort_buf[j] = v;
    end
    if (n % 2 == 0) begin
      sum = {1'b0, sort_buf[n/2-1]} + {1'b0, sort_buf[n/2]};
      return sum[PRES_W:1];
    end
    return sort_buf[n/2];
  endfunction

  // Advance the predictor by one accepted sample and return its result.
  function automatic pres_result_t predict_reference(input logic [PRES_W-1:0] s);
    pres_result_t      r;
    logic [PRES_W-1:0] newest;
    int                i;
    r.taken = 1'b0;
    // No median yet: reference simply tracks the raw sample.
    if (medians_held == 0) ref_level = s;
    window_ring[window_slot] = s;
    window_slot = (window_slot + 1 >= SPM) ? 0 : window_slot + 1;
    window_fill++;
    if (window_fill >= SPM) begin
      // Window closed: the whole sample ring is written by now.
      window_fill = 0;
      r.taken = 1'b1;
      if (medians_held < MK) medians_held++;
      for (i = 0; i < SPM; i++) sort_buf[i] = window_ring[i];
      newest = middle_of_scratch(SPM);
      // Once saturated this overwrites the oldest median.
      median_ring[median_slot] = newest;
      median_slot = (median_slot + 1 >= MK) ? 0 : median_slot + 1;
      if (medians_held == MK) begin
        for (i = 0; i < MK; i++) sort_buf[i] = median_ring[i];
        ref_level = middle_of_scratch(MK);
      end else begin
        ref_level = newest;
      end
    end
    r.reference = ref_level;
    r.settled   = (medians_held == MK);
    return r;
  endfunction

  // Random sample: mostly realistic readings around 1 atm plus a slow drift,
  // with a share of full-range noise and edge patterns.
  function automatic logic [PRES_W-1:0] draw_sample();
    int unsigned       mode;
    int unsigned       bitpos;
    logic [PRES_W-1:0] v;
    mode   = $urandom_range(0, 99);
    bitpos = $urandom_range(0, PRES_W - 1);
    if (mode < 55) begin
      v = PRES_W'(ONE_ATM - 2048 + $urandom_range(0, 4095));
    end else if (mode < 70) begin
      drift_level = drift_level + int'($urandom_range(0, 512)) - 256;
      v = drift_level[PRES_W-1:0];
    end else if (mode < 85) begin
      v = PRES_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = '1;
        2:       v = {{(PRES_W-1){1'b0}}, 1'b1} << bitpos;
        default: v = ~({{(PRES_W-1){1'b0}}, 1'b1} << bitpos);
      endcase
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one request per call. Entered after a rising edge; drives at the
  // falling edge, returns right after the accepting rising edge.
  // ---------------------------------------------------------------------------
  task automatic offer_sample(input logic [PRES_W-1:0] s);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid           <= 1'b0;
      in_chan.pressure_sample <= PRES_W'($urandom);   // junk while idle
      repeat (gap) @(negedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.pressure_sample <= s;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_refs.push_back(predict_reference(s));
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_refs.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Two full windows of edge values. The first window's middle pair sums odd,
  // so the averaged median truncates; the second window's middle pair is near
  // full scale, so the sum needs the carry bit. The very first sample shows
  // the reference following the raw sample.
  task automatic test_window_extremes();
    logic [PRES_W-1:0] first_win [SPM_DEF];
    int                i;
    first_win = '{24'hFFFFFF, 24'h000000, 24'hFFFFFE, 24'h400000, 24'h3FFFFF,
                  24'hFFFFFF, 24'h000001, 24'hAAAAAA, 24'h555555, 24'hFFFFFD};
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (i = 0; i < SPM; i++) offer_sample(first_win[i]);
    for (i = 0; i < SPM; i++) offer_sample((i % 2) ? 24'hFFFFFE : 24'hFFFFFF);
    for (i = 0; i < 4; i++) offer_sample(PRES_W'(ONE_ATM + i));
  endtask

  // Random samples in chunks, each chunk with its own idling mix so that some
  // stretches run back to back on one or both sides.
  task automatic test_random_stream(input int count);
    int i;
    int mix;
    for (i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        mix          = $urandom_range(0, 3);
        src_idle_on  = (mix == 1 || mix == 3);
        sink_idle_on = (mix == 2 || mix == 3);
      end
      offer_sample(draw_sample());
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering;
  // the block fills up and must stall its input without losing anything.
  task automatic test_output_backpressure();
    int i;
    src_idle_on      = 1'b0;
    sink_idle_on     = 1'b0;
    sink_hold_cycles = LONG_HOLD;
    for (i = 0; i < 30; i++) offer_sample(draw_sample());
  endtask

  // Sender stops until every result is out, then resumes mid-window.
  task automatic test_drain_pause();
    int i;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (i = 0; i < 15; i++) offer_sample(draw_sample());
    idle_sender();
    wait_for_drain();
    for (i = 0; i < 15; i++) offer_sample(draw_sample());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random wait before each result, plus a long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (sink_hold_cycles) @(negedge clk);
        sink_hold_cycles = 0;
      end
      gap = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
    end
  end

  // Every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_refs.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual ref %h",
                 $time, out_chan.pressure_reference);
        mismatch_count++;
      end else begin
        expected_ref = pending_refs.pop_front();
        if (out_chan.pressure_reference !== expected_ref.reference) begin
          $display("%0t: pressure_reference mismatch: expected %h, actual %h",
                   $time, expected_ref.reference, out_chan.pressure_reference);
          mismatch_count++;
        end
        if (out_chan.median_taken !== expected_ref.taken) begin
          $display("%0t: median_taken mismatch: expected %b, actual %b",
                   $time, expected_ref.taken, out_chan.median_taken);
          mismatch_count++;
        end
        if (out_chan.reference_settled !== expected_ref.settled) begin
          $display("%0t: reference_settled mismatch: expected %b, actual %b",
                   $time, expected_ref.settled, out_chan.reference_settled);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long with no request or result moving means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_refs.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.pressure_sample = '0;
    out_chan.ready          = 1'b0;
    mismatch_count          = 0;
    stall_cycles            = 0;
    sink_hold_cycles        = 0;
    src_idle_on             = 1'b1;
    sink_idle_on            = 1'b1;
    drift_level             = int'(ONE_ATM);
    window_slot             = 0;
    window_fill             = 0;
    median_slot             = 0;
    medians_held            = 0;
    ref_level               = ONE_ATM;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_window_extremes();
    test_random_stream(150);
    test_output_backpressure();
    test_drain_pause();
    test_random_stream(230);
    idle_sender();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/prmom_pkg.sv
rtl/core/prmom_if.sv
rtl/core/prmom_sorter.sv
rtl/core/prmom_ctrl.sv
rtl/core/prmom_dpath.sv
rtl/core/pressure_reference_median_of_medians.sv
tb/tb.sv
